// ===== design/rgbc_pkg.sv =====
// rgbc_pkg: widths, colour class codes, register indexes and stage payload types
// shared by every module of the rgbc colour classifier; depends on nothing
`timescale 1ns / 1ps

package rgbc_pkg;

    // field and intermediate widths
    localparam int CH_W     = 16;  // raw and scaled channel counts
    localparam int PROD_W   = 32;  // count times gain
    localparam int SUM_W    = 18;  // sum of three scaled channels
    localparam int LIM_W    = 11;  // saturation limit register
    localparam int LIM1_W   = 12;  // saturation limit plus one
    localparam int LHS_W    = 28;  // 3072 * min
    localparam int RHS_W    = 30;  // (limit + 1) * sum
    localparam int HUE_W    = 19;  // signed hue coordinates
    localparam int MAG_W    = 18;  // hue magnitudes
    localparam int CLS_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // colour classes
    typedef enum logic [CLS_W-1:0] {
        CLS_BLACK   = 3'd0,
        CLS_WHITE   = 3'd1,
        CLS_RED     = 3'd2,
        CLS_CYAN    = 3'd3,
        CLS_BLUE    = 3'd4,
        CLS_GREEN   = 3'd5,
        CLS_MAGENTA = 3'd6,
        CLS_YELLOW  = 3'd7
    } color_class_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_PRESENT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_THRESHOLD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION_LIMIT = 3'd5;

    // register reset values
    localparam logic [CH_W-1:0]  GAIN_RESET      = 16'd1024;
    localparam logic [CH_W-1:0]  THRESHOLD_RESET = 16'd0;
    localparam logic [LIM_W-1:0] LIMIT_RESET     = 11'd1025;

    // configuration as seen by the datapath
    typedef struct packed {
        logic             sensor_present;
        logic [CH_W-1:0]  red_gain;
        logic [CH_W-1:0]  green_gain;
        logic [CH_W-1:0]  blue_gain;
        logic [CH_W-1:0]  clear_threshold;
        logic [LIM_W-1:0] saturation_limit;
    } cfg_t;

    // one input sample
    typedef struct packed {
        logic [CH_W-1:0] clear_count;
        logic [CH_W-1:0] red_count;
        logic [CH_W-1:0] green_count;
        logic [CH_W-1:0] blue_count;
    } sample_t;

    // after the gain multipliers
    typedef struct packed {
        logic              force_black;
        logic [PROD_W-1:0] r_prod;
        logic [PROD_W-1:0] g_prod;
        logic [PROD_W-1:0] b_prod;
    } prod_t;

    // scaled channels with min and sum
    typedef struct packed {
        logic             force_black;
        logic [CH_W-1:0]  r;
        logic [CH_W-1:0]  g;
        logic [CH_W-1:0]  b;
        logic [CH_W-1:0]  mn;
        logic [SUM_W-1:0] sum;
    } chan_t;

    // saturation test operands and hue magnitudes
    typedef struct packed {
        logic             force_black;
        logic [LHS_W-1:0] lhs;
        logic [RHS_W-1:0] rhs;
        logic             hx_neg;
        logic             hy_neg;
        logic [MAG_W-1:0] hx_mag;
        logic [MAG_W-1:0] hy_mag;
    } metric_t;

endpackage

// ===== design/rgbc_scale.sv =====
// rgbc_scale: gain multiplier stage and channel scaling / min / sum stage
// uses rgbc_pkg
`timescale 1ns / 1ps

module rgbc_scale #(
    parameter int GAIN_FRAC_BITS = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  rgbc_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  rgbc_pkg::sample_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rgbc_pkg::chan_t   out_data
);
    import rgbc_pkg::*;

    logic    v1_reg, v2_reg;
    logic    ready1, ready2;
    prod_t   p1_reg, p1_next;
    chan_t   p2_reg, p2_next;
    logic [CH_W-1:0] r_s, g_s, b_s;

    // per-stage ready: a stage takes an item when empty or when its item moves on
    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    // stage 1: gain multipliers, black test
    always_comb begin
        p1_next.force_black = !cfg.sensor_present || (in_data.clear_count < cfg.clear_threshold);
        p1_next.r_prod = PROD_W'(in_data.red_count)   * PROD_W'(cfg.red_gain);
        p1_next.g_prod = PROD_W'(in_data.green_count) * PROD_W'(cfg.green_gain);
        p1_next.b_prod = PROD_W'(in_data.blue_count)  * PROD_W'(cfg.blue_gain);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ready1) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            p1_reg <= p1_next;
        end
    end

    // stage 2: drop fraction bits, keep 16 bits, min and sum
    assign r_s = p1_reg.r_prod[GAIN_FRAC_BITS +: CH_W];
    assign g_s = p1_reg.g_prod[GAIN_FRAC_BITS +: CH_W];
    assign b_s = p1_reg.b_prod[GAIN_FRAC_BITS +: CH_W];

    always_comb begin
        logic [CH_W-1:0] m;
        m = r_s;
        if (g_s < m) m = g_s;
        if (b_s < m) m = b_s;
        p2_next.force_black = p1_reg.force_black;
        p2_next.r   = r_s;
        p2_next.g   = g_s;
        p2_next.b   = b_s;
        p2_next.mn  = m;
        p2_next.sum = SUM_W'(r_s) + SUM_W'(g_s) + SUM_W'(b_s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ready2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && v1_reg) begin
            p2_reg <= p2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = p2_reg;

endmodule

// ===== design/rgbc_metric.sv =====
// rgbc_metric: saturation test operands and hue coordinate magnitudes
// uses rgbc_pkg
`timescale 1ns / 1ps

module rgbc_metric (
    input  logic             aclk,
    input  logic             aresetn,
    input  rgbc_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  rgbc_pkg::chan_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rgbc_pkg::metric_t out_data
);
    import rgbc_pkg::*;

    logic    v_reg;
    metric_t p_reg, p_next;
    logic [LIM1_W-1:0] lim1;
    logic [HUE_W-1:0]  hx, hy, gb;

    assign in_ready = !v_reg || out_ready;

    // inverse saturation above the limit is 3072*min >= (limit+1)*sum, no divider
    assign lim1 = LIM1_W'(cfg.saturation_limit) + LIM1_W'(1);

    // two's complement hue coordinates
    assign hx = HUE_W'({in_data.r, 1'b0}) - HUE_W'(in_data.g) - HUE_W'(in_data.b);
    assign gb = HUE_W'(in_data.g) - HUE_W'(in_data.b);
    assign hy = (gb << 1) + gb;

    always_comb begin
        p_next.force_black = in_data.force_black;
        p_next.lhs = (LHS_W'(in_data.mn) << 11) + (LHS_W'(in_data.mn) << 10);
        p_next.rhs = RHS_W'(in_data.sum) * RHS_W'(lim1);
        p_next.hx_neg = hx[HUE_W-1];
        p_next.hy_neg = hy[HUE_W-1];
        p_next.hx_mag = hx[HUE_W-1] ? MAG_W'(-hx) : MAG_W'(hx);
        p_next.hy_mag = hy[HUE_W-1] ? MAG_W'(-hy) : MAG_W'(hy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            p_reg <= p_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = p_reg;

endmodule

// ===== design/rgbc_decide.sv =====
// rgbc_decide: final class selection into the output register
// uses rgbc_pkg
`timescale 1ns / 1ps

module rgbc_decide (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rgbc_pkg::metric_t      in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rgbc_pkg::color_class_t out_class
);
    import rgbc_pkg::*;

    logic         v_reg;
    color_class_t cls_reg, cls_next;
    logic         white;

    assign in_ready = !v_reg || out_ready;

    // a zero sum gives 0 >= 0 here, so it lands on white as well
    assign white = RHS_W'(in_data.lhs) >= in_data.rhs;

    // black over white over hue sector
    always_comb begin
        if (in_data.force_black) begin
            cls_next = CLS_BLACK;
        end else if (white) begin
            cls_next = CLS_WHITE;
        end else if (in_data.hx_mag > in_data.hy_mag) begin
            cls_next = in_data.hx_neg ? CLS_CYAN : CLS_RED;
        end else if (in_data.hx_neg) begin
            cls_next = in_data.hy_neg ? CLS_BLUE : CLS_GREEN;
        end else begin
            cls_next = in_data.hy_neg ? CLS_MAGENTA : CLS_YELLOW;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            cls_reg <= cls_next;
        end
    end

    assign out_valid = v_reg;
    assign out_class = cls_reg;

endmodule

// ===== design/rgbc_color_classifier_top.sv =====
// RGBC colour classifier: one result item per sample item, four register stages
// (gain multiply, scale/min/sum, saturation and hue operands, class select).
// One item is taken every cycle while the output is drained, and each stage
// holds its item under back-pressure, so a bubble anywhere lets a new item in.
// Registers are to be written through cfg_wr_* only while no item is in flight;
// the block itself does not enforce this. Uses rgbc_pkg and the rgbc_scale,
// rgbc_metric and rgbc_decide stages.
`timescale 1ns / 1ps

module rgbc_color_classifier_top #(
    parameter int GAIN_FRAC_BITS = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [rgbc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // sample items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] clear_count, [31:16] red_count, [47:32] green_count, [63:48] blue_count
    input  logic [63:0]                   s_tdata,
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] color_class, [7:3] zero
    output logic [7:0]                    m_tdata
);
    import rgbc_pkg::*;

    cfg_t         cfg_reg;
    sample_t      sample;
    chan_t        chan;
    metric_t      metric;
    color_class_t cls;
    logic         chan_valid, chan_ready, metric_valid, metric_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensor_present   <= 1'b0;
            cfg_reg.red_gain         <= GAIN_RESET;
            cfg_reg.green_gain       <= GAIN_RESET;
            cfg_reg.blue_gain        <= GAIN_RESET;
            cfg_reg.clear_threshold  <= THRESHOLD_RESET;
            cfg_reg.saturation_limit <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_SENSOR_PRESENT:   cfg_reg.sensor_present   <= cfg_wr_data[0];
                REG_RED_GAIN:         cfg_reg.red_gain         <= cfg_wr_data;
                REG_GREEN_GAIN:       cfg_reg.green_gain       <= cfg_wr_data;
                REG_BLUE_GAIN:        cfg_reg.blue_gain        <= cfg_wr_data;
                REG_CLEAR_THRESHOLD:  cfg_reg.clear_threshold  <= cfg_wr_data;
                REG_SATURATION_LIMIT: cfg_reg.saturation_limit <= cfg_wr_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the sample item
    assign sample.clear_count = s_tdata[15:0];
    assign sample.red_count   = s_tdata[31:16];
    assign sample.green_count = s_tdata[47:32];
    assign sample.blue_count  = s_tdata[63:48];

    rgbc_scale #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (sample),
        .out_valid (chan_valid),
        .out_ready (chan_ready),
        .out_data  (chan)
    );

    rgbc_metric u_metric (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (chan_valid),
        .in_ready  (chan_ready),
        .in_data   (chan),
        .out_valid (metric_valid),
        .out_ready (metric_ready),
        .out_data  (metric)
    );

    rgbc_decide u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (metric_valid),
        .in_ready  (metric_ready),
        .in_data   (metric),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_class (cls)
    );

    assign m_tdata = {5'b0, cls};

endmodule

// ===== verif/rgbc_color_checker.sv =====
// rgbc_color_checker: watches the sample, result and register ports of the rgbc
// colour classifier, predicts each colour class and compares; uses rgbc_pkg
`timescale 1ns / 1ps

module rgbc_color_checker #(
    parameter int GAIN_FRAC_BITS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [rgbc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [15:0] clear_count, [31:16] red_count, [47:32] green_count, [63:48] blue_count
    input  logic [63:0]                     s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] color_class, [7:3] zero
    input  logic [7:0]                      m_tdata,
    output int                              mismatch_count,
    output int                              pending_count
);
    import rgbc_pkg::*;

    cfg_t         shadow_cfg;
    color_class_t class_q[$];

    // colour class of one sample under the given register settings
    function automatic color_class_t classify_sample(input sample_t smp, input cfg_t cfg);
        logic [PROD_W-1:0] r_prod, g_prod, b_prod;
        logic [CH_W-1:0]   r, g, b, mn;
        longint unsigned   sum, inv;
        longint            rs, gs, bs, hx, hy, hx_mag, hy_mag;
        if (!cfg.sensor_present)
            return CLS_BLACK;
        r_prod = PROD_W'(smp.red_count) * PROD_W'(cfg.red_gain);
        g_prod = PROD_W'(smp.green_count) * PROD_W'(cfg.green_gain);
        b_prod = PROD_W'(smp.blue_count) * PROD_W'(cfg.blue_gain);
        // scaled channels keep only their low 16 bits
        r = CH_W'(r_prod >> GAIN_FRAC_BITS);
        g = CH_W'(g_prod >> GAIN_FRAC_BITS);
        b = CH_W'(b_prod >> GAIN_FRAC_BITS);
        if (smp.clear_count < cfg.clear_threshold)
            return CLS_BLACK;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = longint'(r) + longint'(g) + longint'(b);
        if (sum == 0)
            return CLS_WHITE;
        inv = (64'd3072 * mn) / sum;
        if (inv > cfg.saturation_limit)
            return CLS_WHITE;
        rs = longint'(r);
        gs = longint'(g);
        bs = longint'(b);
        hy = 3 * (gs - bs);
        hx = 2 * rs - gs - bs;
        hx_mag = (hx < 0) ? -hx : hx;
        hy_mag = (hy < 0) ? -hy : hy;
        if (hx_mag > hy_mag)
            return (hx < 0) ? CLS_CYAN : CLS_RED;
        if (hx < 0)
            return (hy < 0) ? CLS_BLUE : CLS_GREEN;
        return (hy < 0) ? CLS_MAGENTA : CLS_YELLOW;
    endfunction

    // register shadow, prediction on accepted samples, compare on accepted results
    always @(posedge aclk) begin
        sample_t      smp;
        color_class_t want;
        int           pushed, popped;
        pushed = 0;
        popped = 0;
        if (!aresetn) begin
            shadow_cfg.sensor_present   <= 1'b0;
            shadow_cfg.red_gain         <= GAIN_RESET;
            shadow_cfg.green_gain       <= GAIN_RESET;
            shadow_cfg.blue_gain        <= GAIN_RESET;
            shadow_cfg.clear_threshold  <= THRESHOLD_RESET;
            shadow_cfg.saturation_limit <= LIMIT_RESET;
            class_q.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_SENSOR_PRESENT:   shadow_cfg.sensor_present   <= cfg_wr_data[0];
                    REG_RED_GAIN:         shadow_cfg.red_gain         <= cfg_wr_data;
                    REG_GREEN_GAIN:       shadow_cfg.green_gain       <= cfg_wr_data;
                    REG_BLUE_GAIN:        shadow_cfg.blue_gain        <= cfg_wr_data;
                    REG_CLEAR_THRESHOLD:  shadow_cfg.clear_threshold  <= cfg_wr_data;
                    REG_SATURATION_LIMIT: shadow_cfg.saturation_limit <= cfg_wr_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                smp.clear_count = s_tdata[15:0];
                smp.red_count   = s_tdata[31:16];
                smp.green_count = s_tdata[47:32];
                smp.blue_count  = s_tdata[63:48];
                class_q.push_back(classify_sample(smp, shadow_cfg));
                pushed = 1;
            end
            if (m_tvalid && m_tready) begin
                if (class_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result item %0d with no sample waiting", $realtime,
                                 m_tdata);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = class_q.pop_front();
                    popped = 1;
                    if (m_tdata !== {5'b0, want}) begin
                        if (mismatch_count < 10)
                            $display("%0t: colour class mismatch, expected %0d got %0d",
                                     $realtime, want, m_tdata);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            pending_count <= pending_count + pushed - popped;
        end
    end

endmodule

// ===== verif/rgbc_color_classifier_top_tb.sv =====
// rgbc_color_classifier_top_tb: drives samples, register writes and back-pressure
// into rgbc_color_classifier_top; checking is done by rgbc_color_checker (rgbc_pkg)
`timescale 1ns / 1ps

module rgbc_color_classifier_top_tb;
    import rgbc_pkg::*;

    localparam int GAIN_FRAC_BITS  = 10;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 10;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 75;
    // indexes past the last register, writes there are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    int                    mismatch_count;
    int                    pending_count;

    int                    burst_left;
    bit                    hold_req;
    logic [CH_W-1:0]       threshold_now;

    rgbc_color_classifier_top #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    rgbc_color_checker #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count)
    );

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // hard stop
    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random ready patterns, with a long hold-off on request
    initial begin
        int mode, len, hold_left;
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            repeat (len) begin
                @(posedge aclk);
                if (hold_req) begin
                    hold_req  = 1'b0;
                    hold_left = HOLD_CYCLES;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    m_tready <= 1'b0;
                end else begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= ($urandom_range(0, 1) == 1);
                        2: m_tready <= ($urandom_range(0, 3) != 0);
                        default: m_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // one sample item, sent in bursts with random gaps
    task automatic send_sample(input logic [15:0] c, r, g, b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 30);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r, c};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait until every result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        // let the count take in the item accepted at this edge
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic present, input logic [15:0] rg, gg, bg,
                                 input logic [15:0] thr, input logic [15:0] lim);
        write_reg(REG_SENSOR_PRESENT, {15'b0, present});
        write_reg(REG_RED_GAIN, rg);
        write_reg(REG_GREEN_GAIN, gg);
        write_reg(REG_BLUE_GAIN, bg);
        write_reg(REG_CLEAR_THRESHOLD, thr);
        write_reg(REG_SATURATION_LIMIT, lim);
        threshold_now = thr;
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0, 1: return GAIN_RESET;
            2: return 16'd0;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(512, 2048));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_setting(input bit force_present);
        logic            present;
        logic [15:0]     rg, gg, bg, thr, lim;
        present = force_present || ($urandom_range(0, 7) != 0);
        rg = pick_gain();
        gg = pick_gain();
        bg = pick_gain();
        case ($urandom_range(0, 3))
            0, 1: thr = 16'd0;
            2: thr = 16'($urandom_range(0, 4000));
            default: thr = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 3))
            0: lim = 16'(LIMIT_RESET);
            1: lim = 16'd0;
            default: lim = 16'($urandom_range(0, 1025));
        endcase
        apply_setting(present, rg, gg, bg, thr, lim);
    endtask

    // random sample packed as on s_tdata, with a mix of shapes
    function automatic logic [63:0] random_sample(input logic [15:0] thr);
        logic [15:0] c, r, g, b;
        int          k;
        c = 16'($urandom_range(0, 65535));
        r = 16'($urandom_range(0, 65535));
        g = 16'($urandom_range(0, 65535));
        b = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 5))
            2: begin
                // each channel is made small at random, so one or two may dominate
                if ($urandom_range(0, 1) == 0) r = 16'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 0) g = 16'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 0) b = 16'($urandom_range(0, 255));
            end
            3: begin
                // hue magnitudes equal at unity gain
                k = $urandom_range(0, 21845);
                case ($urandom_range(0, 3))
                    0: begin r = 16'(2 * k); g = 16'(k); b = 16'd0; end
                    1: begin r = 16'(2 * k); g = 16'd0; b = 16'(k); end
                    2: begin r = 16'd0; g = 16'(k); b = 16'(2 * k); end
                    default: begin r = 16'd0; g = 16'(2 * k); b = 16'(k); end
                endcase
            end
            4: begin
                r = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd0;
                g = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd0;
                b = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd0;
            end
            5: begin
                r = 16'($urandom_range(0, 3));
                g = 16'($urandom_range(0, 3));
                b = 16'($urandom_range(0, 3));
            end
            default: ;
        endcase
        // clear count on or just under the threshold
        case ($urandom_range(0, 5))
            0: c = thr;
            1: c = thr - 16'd1;
            default: ;
        endcase
        return {b, g, r, c};
    endfunction

    // stimulus and verdict
    initial begin
        logic [63:0] smp;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_index  = '0;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        hold_req      = 1'b0;
        burst_left    = 0;
        threshold_now = THRESHOLD_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sensor absent after reset: always black
        send_sample(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        send_sample(16'd0, 16'd0, 16'd0, 16'd0);
        wait_idle();

        // sensor present, unity gains
        write_reg(REG_SENSOR_PRESENT, 16'd1);
        send_sample(16'd0, 16'd0, 16'd0, 16'd0);              // zero sum
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // grey at full scale
        send_sample(16'd100, 16'd60000, 16'd100, 16'd100);
        send_sample(16'd100, 16'd100, 16'd60000, 16'd60000);
        send_sample(16'd100, 16'd100, 16'd100, 16'd60000);
        send_sample(16'd100, 16'd100, 16'd60000, 16'd100);
        send_sample(16'd100, 16'd60000, 16'd100, 16'd60000);
        send_sample(16'd100, 16'd60000, 16'd60000, 16'd100);
        // equal hue magnitudes, one per sign combination
        send_sample(16'd500, 16'd2000, 16'd1000, 16'd0);
        send_sample(16'd500, 16'd2000, 16'd0, 16'd1000);
        send_sample(16'd500, 16'd0, 16'd1000, 16'd2000);
        send_sample(16'd500, 16'd0, 16'd2000, 16'd1000);
        wait_idle();

        // uneven gains, threshold and a tight limit
        apply_setting(1'b1, 16'd2048, 16'd512, 16'hFFFF, 16'd1000, 16'd512);
        send_sample(16'd999, 16'd3000, 16'd100, 16'd100);
        send_sample(16'd1000, 16'd3000, 16'd100, 16'd100);
        send_sample(16'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // gain overflow
        send_sample(16'd5000, 16'd30000, 16'd60000, 16'd1000);
        wait_idle();

        // zero gains, top threshold, zero limit
        apply_setting(1'b1, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
        send_sample(16'hFFFF, 16'd40000, 16'd20000, 16'd10000);
        send_sample(16'hFFFE, 16'd40000, 16'd20000, 16'd10000);
        wait_idle();

        // out of range limit value and writes past the last register
        apply_setting(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0000);
        send_sample(16'd7, 16'd1000, 16'd1000, 16'd1000);
        send_sample(16'd7, 16'd10, 16'd20, 16'd3000);
        wait_idle();

        // random settings, each followed by a run of random samples
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_setting(p == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ((p == 1 && n == 10) || (p == 4 && n == 30))
                    hold_req = 1'b1;
                smp = random_sample(threshold_now);
                send_sample(smp[15:0], smp[31:16], smp[47:32], smp[63:48]);
            end
            wait_idle();
        end

        if (mismatch_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
